@@ design/scpr_pkg.sv @@
`default_nettype none
package scpr_pkg;

  localparam int MAX_FRAMES_DEF = 16;
  localparam int PAGE_BITS_DEF  = 16;

  localparam int FIU_W   = 5;
  localparam int PAGE_W  = 16;
  localparam int SLOT_W  = 4;
  localparam int FAULT_W = 32;

  localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic sweep;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic fill;
    logic found;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

@@ design/scpr_ctrl.sv @@
`default_nettype none
module scpr_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  scpr_pkg::sts_t    sts_i,
  output scpr_pkg::cmd_t    cmd_o
);
  import scpr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOOK  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d        = state_q;
    cmd_o.capture  = 1'b0;
    cmd_o.lookup   = 1'b0;
    cmd_o.sweep    = 1'b0;
    cmd_o.publish  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          state_d       = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.lookup = 1'b1;
        if (sts_i.hit || sts_i.fill) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.found) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (!sts_i.out_busy) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ design/scpr_dp.sv @@
`default_nettype none
module scpr_dp #(
  parameter int MAX_FRAMES = scpr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = scpr_pkg::PAGE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [scpr_pkg::FIU_W-1:0]    cfg_wdata_i,
  input  wire logic [scpr_pkg::PAGE_W-1:0]   page_number_i,
  input  scpr_pkg::cmd_t                     cmd_i,
  output scpr_pkg::sts_t                     sts_o,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic                               page_hit_o,
  output logic [scpr_pkg::SLOT_W-1:0]        frame_slot_o,
  output logic                               evicted_valid_o,
  output logic [scpr_pkg::PAGE_W-1:0]        evicted_page_o,
  output logic [scpr_pkg::FAULT_W-1:0]       fault_total_o
);
  import scpr_pkg::*;

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  // control state
  logic [FIU_W-1:0]    fiu_q;
  logic [CNT_W-1:0]    filled_q, filled_d;
  logic [IDX_W-1:0]    hand_q, hand_d;
  logic [FAULT_W-1:0]  fault_q, fault_d;
  logic                out_valid_q, out_valid_d;

  // payload state
  logic [PAGE_BITS-1:0] frame_q [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] refb_q;
  logic [PAGE_BITS-1:0] page_q;
  logic                 res_hit_q;
  logic [IDX_W-1:0]     res_slot_q;
  logic                 res_evv_q;
  logic [PAGE_BITS-1:0] res_old_q;
  logic                 out_hit_q;
  logic [SLOT_W-1:0]    out_slot_q;
  logic                 out_evv_q;
  logic [PAGE_W-1:0]    out_old_q;
  logic [FAULT_W-1:0]   out_fault_q;

  logic [31:0]          page_ext;
  logic [31:0]          slot_ext;
  logic [31:0]          old_ext;
  logic [CNT_W-1:0]     limit;
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;
  logic                 fill;
  logic [CNT_W-1:0]     filled_inc;
  logic [CNT_W-1:0]     hand_inc;
  logic [IDX_W-1:0]     hand_step;
  logic [IDX_W-1:0]     fill_idx;
  logic                 found;
  logic                 miss;

  assign page_ext = 32'(page_number_i);
  assign slot_ext = 32'(res_slot_q);
  assign old_ext  = 32'(res_old_q);

  // clamp the frame count register into 1..MAX_FRAMES
  always_comb begin
    if (fiu_q == '0) begin
      limit = CNT_W'(1);
    end else if (32'(fiu_q) > MAX_FRAMES) begin
      limit = CNT_W'(MAX_FRAMES);
    end else begin
      limit = CNT_W'(fiu_q);
    end
  end

  // parallel tag compare, lowest matching frame wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if ((32'(i) < 32'(filled_q)) && (frame_q[i] == page_q)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign fill       = (filled_q < limit);
  assign filled_inc = filled_q + CNT_W'(1);
  assign fill_idx   = filled_q[IDX_W-1:0];
  assign hand_inc   = CNT_W'(hand_q) + CNT_W'(1);
  assign hand_step  = (hand_inc >= filled_q) ? '0 : hand_inc[IDX_W-1:0];
  assign found      = !refb_q[hand_q];
  assign miss       = cmd_i.lookup && !hit;

  assign sts_o.hit      = hit;
  assign sts_o.fill     = fill;
  assign sts_o.found    = found;
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  always_comb begin
    filled_d = filled_q;
    hand_d   = hand_q;
    fault_d  = fault_q;
    if (cmd_i.lookup && !hit) begin
      if (fill) begin
        filled_d = filled_inc;
        if (filled_inc == limit) begin
          hand_d = '0;
        end else begin
          hand_d = hand_q + IDX_W'(1);
        end
      end else if (CNT_W'(hand_q) >= filled_q) begin
        hand_d = '0;
      end
    end
    if (cmd_i.sweep) begin
      hand_d = hand_step;
    end
    if (miss && (fault_q != '1)) begin
      fault_d = fault_q + FAULT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.publish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q       <= FIU_RESET;
      filled_q    <= '0;
      hand_q      <= '0;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fiu_q <= cfg_wdata_i;
      end
      filled_q    <= filled_d;
      hand_q      <= hand_d;
      fault_q     <= fault_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      page_q <= page_ext[PAGE_BITS-1:0];
    end
    if (cmd_i.lookup) begin
      if (hit) begin
        refb_q[hit_idx] <= 1'b1;
        res_hit_q       <= 1'b1;
        res_slot_q      <= hit_idx;
        res_evv_q       <= 1'b0;
        res_old_q       <= '0;
      end else if (fill) begin
        frame_q[fill_idx] <= page_q;
        refb_q[fill_idx]  <= 1'b0;
        res_hit_q         <= 1'b0;
        res_slot_q        <= fill_idx;
        res_evv_q         <= 1'b0;
        res_old_q         <= '0;
      end
    end
    if (cmd_i.sweep) begin
      // give a second chance, or replace on a clear bit
      refb_q[hand_q] <= 1'b0;
      if (found) begin
        frame_q[hand_q] <= page_q;
        res_hit_q       <= 1'b0;
        res_slot_q      <= hand_q;
        res_evv_q       <= 1'b1;
        res_old_q       <= frame_q[hand_q];
      end
    end
    if (cmd_i.publish) begin
      out_hit_q   <= res_hit_q;
      out_slot_q  <= slot_ext[SLOT_W-1:0];
      out_evv_q   <= res_evv_q;
      out_old_q   <= old_ext[PAGE_W-1:0];
      out_fault_q <= fault_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign page_hit_o      = out_hit_q;
  assign frame_slot_o    = out_slot_q;
  assign evicted_valid_o = out_evv_q;
  assign evicted_page_o  = out_old_q;
  assign fault_total_o   = out_fault_q;

endmodule
`default_nettype wire

@@ design/second_chance_page_replacer.sv @@
// Flow: an accepted word is captured and looked up; on a hit or a fill its
//   result is published to the output register, and on a replacement the
//   clock sweep first visits up to the number of filled frames plus one,
//   one stored frame tested per cycle. Only one word is taken at a time;
//   the next is accepted after publish, and a waiting result adds stall time.
// Reset: clears fill count, hand, fault total and output valid, frame count to
//   16; frame contents and reference bits are not cleared and need no sweep.
`default_nettype none
module second_chance_page_replacer #(
  parameter int MAX_FRAMES = scpr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = scpr_pkg::PAGE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [scpr_pkg::FIU_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [scpr_pkg::PAGE_W-1:0]   page_number_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               page_hit_o,
  output logic [scpr_pkg::SLOT_W-1:0]        frame_slot_o,
  output logic                               evicted_valid_o,
  output logic [scpr_pkg::PAGE_W-1:0]        evicted_page_o,
  output logic [scpr_pkg::FAULT_W-1:0]       fault_total_o
);
  import scpr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  scpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  scpr_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .page_number_i   (page_number_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .page_hit_o      (page_hit_o),
    .frame_slot_o    (frame_slot_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_total_o   (fault_total_o)
  );

endmodule
`default_nettype wire

@@ design/scpr_chk.sv @@
`default_nettype none
module scpr_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        page_hit_o,
  input wire logic        evicted_valid_o,
  input wire logic [15:0] evicted_page_o
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // one word in flight: input closes right after an accept
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open while a word is in flight");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && page_hit_o |-> !evicted_valid_o)
    else $error("hit reported an eviction");

  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_valid_o |-> (evicted_page_o == 16'd0))
    else $error("evicted page nonzero without eviction");

endmodule

bind second_chance_page_replacer scpr_chk u_scpr_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .page_hit_o      (page_hit_o),
  .evicted_valid_o (evicted_valid_o),
  .evicted_page_o  (evicted_page_o)
);
`default_nettype wire
